/* rtl/kdop_pkg.sv */
`default_nettype none

package kdop_pkg;

	localparam int DIRECTIONS_DEF  = 9;
	localparam int COORD_WIDTH_DEF = 32;
	localparam int TABLE_SIZE      = 9;
	localparam int IDX_WIDTH       = 4;
	localparam int CNT_WIDTH       = 4;

	localparam logic [CNT_WIDTH-1:0] DIR_COUNT_RESET = CNT_WIDTH'(9);

	typedef logic signed [1:0] coef_t;

	// Coefficients of x, y, z per direction: x, y, y-x, y+x, z, z-x, z+x, z-y, z+y
	localparam coef_t COEF_X [TABLE_SIZE] = '{
		2'sd1, 2'sd0, -2'sd1, 2'sd1, 2'sd0, -2'sd1, 2'sd1, 2'sd0, 2'sd0};
	localparam coef_t COEF_Y [TABLE_SIZE] = '{
		2'sd0, 2'sd1, 2'sd1, 2'sd1, 2'sd0, 2'sd0, 2'sd0, -2'sd1, 2'sd1};
	localparam coef_t COEF_Z [TABLE_SIZE] = '{
		2'sd0, 2'sd0, 2'sd0, 2'sd0, 2'sd1, 2'sd1, 2'sd1, 2'sd1, 2'sd1};

endpackage

`default_nettype wire

/* rtl/kdop_if.sv */
`default_nettype none

interface kdop_node_if #(
	parameter int COORD_WIDTH = kdop_pkg::COORD_WIDTH_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] coord_x;
	logic signed [COORD_WIDTH-1:0] coord_y;
	logic signed [COORD_WIDTH-1:0] coord_z;
	logic                          last_node;

	modport source (output valid, coord_x, coord_y, coord_z, last_node, input ready);
	modport sink   (input valid, coord_x, coord_y, coord_z, last_node, output ready);
endinterface

interface kdop_bound_if #(
	parameter int COORD_WIDTH = kdop_pkg::COORD_WIDTH_DEF
);
	logic                              valid;
	logic                              ready;
	logic [kdop_pkg::IDX_WIDTH-1:0]    direction_index;
	logic signed [COORD_WIDTH:0]       bound_low;
	logic signed [COORD_WIDTH:0]       bound_high;
	logic                              last_bound;

	modport source (output valid, direction_index, bound_low, bound_high, last_bound,
		input ready);
	modport sink   (input valid, direction_index, bound_low, bound_high, last_bound,
		output ready);
endinterface

`default_nettype wire

/* rtl/kdop_bounds_accumulator.sv */
`default_nettype none

// k-DOP bounds accumulator. Each node transaction carries x, y, z of one mesh
// element node in signed Q16.16. The node is projected onto the first
// DIRECTIONS axes of the table x, y, y-x, y+x, z, z-x, z+x, z-y, z+y, and a
// running minimum and maximum per axis is kept in Q17.16 (exact, no rounding,
// no saturation); the first node of an element seeds both. On the node marked
// last_node the final bounds are copied into an output snapshot and one bound
// transaction per axis follows, direction_index 0 upward, the final one flagged
// by last_bound. The count emitted is cfg_wdata as written via cfg_we (reset 9),
// with zero taken as 1 and anything above DIRECTIONS taken as DIRECTIONS; write
// it only while the block is idle. Rate: one node per cycle through the input
// register and the compare stage. An element yields its count of bound
// transactions at one per cycle from the snapshot while bound.ready is high,
// and the next element already accumulates meanwhile; a last node that arrives
// while the snapshot is still draining holds in the input register until the
// snapshot's final transaction is taken.
module kdop_bounds_accumulator #(
	parameter int DIRECTIONS  = kdop_pkg::DIRECTIONS_DEF,
	parameter int COORD_WIDTH = kdop_pkg::COORD_WIDTH_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [kdop_pkg::CNT_WIDTH-1:0] cfg_wdata,
	kdop_node_if.sink                           node,
	kdop_bound_if.source                        bound
);
	logic [kdop_pkg::CNT_WIDTH-1:0] direction_count_q;
	logic                           load_valid;
	logic                           snap_free;
	logic signed [COORD_WIDTH:0]    load_low  [DIRECTIONS];
	logic signed [COORD_WIDTH:0]    load_high [DIRECTIONS];

	// hold the direction count; it is sampled when an element closes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			direction_count_q <= kdop_pkg::DIR_COUNT_RESET;
		end else if (cfg_we) begin
			direction_count_q <= cfg_wdata;
		end
	end

	// input register, projections and running min/max per axis
	kdop_track #(
		.DIRECTIONS  (DIRECTIONS),
		.COORD_WIDTH (COORD_WIDTH)
	) u_track (
		.clk        (clk),
		.arst_n     (arst_n),
		.node       (node),
		.snap_free  (snap_free),
		.load_valid (load_valid),
		.load_low   (load_low),
		.load_high  (load_high)
	);

	// snapshot of a finished element, drained one axis per transaction
	kdop_emit #(
		.DIRECTIONS  (DIRECTIONS),
		.COORD_WIDTH (COORD_WIDTH)
	) u_emit (
		.clk             (clk),
		.arst_n          (arst_n),
		.direction_count (direction_count_q),
		.load_valid      (load_valid),
		.load_low        (load_low),
		.load_high       (load_high),
		.snap_free       (snap_free),
		.bound           (bound)
	);

endmodule

`default_nettype wire

/* rtl/kdop_track.sv */
`default_nettype none

module kdop_track #(
	parameter int DIRECTIONS  = kdop_pkg::DIRECTIONS_DEF,
	parameter int COORD_WIDTH = kdop_pkg::COORD_WIDTH_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	kdop_node_if.sink                      node,
	input  wire logic                      snap_free,
	output logic                           load_valid,
	output logic signed [COORD_WIDTH:0]    load_low  [DIRECTIONS],
	output logic signed [COORD_WIDTH:0]    load_high [DIRECTIONS]
);
	localparam int BW = COORD_WIDTH + 1;

	logic                          valid_s1;
	logic                          last_s1;
	logic signed [COORD_WIDTH-1:0] x_s1, y_s1, z_s1;
	logic                          first_pending_q;
	logic signed [BW-1:0]          running_low_q  [DIRECTIONS];
	logic signed [BW-1:0]          running_high_q [DIRECTIONS];
	logic signed [BW-1:0]          xe, ye, ze;
	logic                          advance;
	logic                          take;

	assign xe = {x_s1[COORD_WIDTH-1], x_s1};
	assign ye = {y_s1[COORD_WIDTH-1], y_s1};
	assign ze = {z_s1[COORD_WIDTH-1], z_s1};

	// a last node waits until the snapshot can take the finished bounds
	assign advance    = valid_s1 && (!last_s1 || snap_free);
	assign node.ready = !valid_s1 || advance;
	assign take       = node.valid && node.ready;
	assign load_valid = advance && last_s1;

	for (genvar d = 0; d < DIRECTIONS; d++) begin : g_dir
		logic signed [BW-1:0] tx, ty, tz, proj;

		assign tx = (kdop_pkg::COEF_X[d] > 0) ? xe :
			(kdop_pkg::COEF_X[d] < 0) ? -xe : '0;
		assign ty = (kdop_pkg::COEF_Y[d] > 0) ? ye :
			(kdop_pkg::COEF_Y[d] < 0) ? -ye : '0;
		assign tz = (kdop_pkg::COEF_Z[d] > 0) ? ze :
			(kdop_pkg::COEF_Z[d] < 0) ? -ze : '0;
		assign proj = tx + ty + tz;

		always_comb begin
			if (first_pending_q) begin
				load_low[d]  = proj;
				load_high[d] = proj;
			end else begin
				load_low[d]  = (proj < running_low_q[d])  ? proj : running_low_q[d];
				load_high[d] = (proj > running_high_q[d]) ? proj : running_high_q[d];
			end
		end

		always_ff @(posedge clk) begin
			if (advance) begin
				running_low_q[d]  <= load_low[d];
				running_high_q[d] <= load_high[d];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1        <= 1'b0;
			first_pending_q <= 1'b1;
		end else begin
			if (take) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				first_pending_q <= last_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			x_s1    <= node.coord_x;
			y_s1    <= node.coord_y;
			z_s1    <= node.coord_z;
			last_s1 <= node.last_node;
		end
	end

endmodule

`default_nettype wire

/* rtl/kdop_emit.sv */
`default_nettype none

module kdop_emit #(
	parameter int DIRECTIONS  = kdop_pkg::DIRECTIONS_DEF,
	parameter int COORD_WIDTH = kdop_pkg::COORD_WIDTH_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic [kdop_pkg::CNT_WIDTH-1:0]   direction_count,
	input  wire logic                             load_valid,
	input  wire logic signed [COORD_WIDTH:0]      load_low  [DIRECTIONS],
	input  wire logic signed [COORD_WIDTH:0]      load_high [DIRECTIONS],
	output logic                                  snap_free,
	kdop_bound_if.source                          bound
);
	localparam int BW = COORD_WIDTH + 1;
	localparam logic [kdop_pkg::CNT_WIDTH-1:0] MAX_COUNT = kdop_pkg::CNT_WIDTH'(DIRECTIONS);

	logic                              busy_q;
	logic [kdop_pkg::IDX_WIDTH-1:0]    idx_q;
	logic [kdop_pkg::IDX_WIDTH-1:0]    last_idx_q;
	logic signed [BW-1:0]              snap_low_q  [DIRECTIONS];
	logic signed [BW-1:0]              snap_high_q [DIRECTIONS];
	logic [kdop_pkg::CNT_WIDTH-1:0]    count_clamped;
	logic                              at_last;
	logic                              out_take;

	always_comb begin
		if (direction_count == '0) begin
			count_clamped = kdop_pkg::CNT_WIDTH'(1);
		end else if (direction_count > MAX_COUNT) begin
			count_clamped = MAX_COUNT;
		end else begin
			count_clamped = direction_count;
		end
	end

	assign at_last   = (idx_q == last_idx_q);
	assign out_take  = bound.valid && bound.ready;
	assign snap_free = !busy_q || (out_take && at_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			idx_q      <= '0;
			last_idx_q <= '0;
		end else if (load_valid) begin
			busy_q     <= 1'b1;
			idx_q      <= '0;
			last_idx_q <= kdop_pkg::IDX_WIDTH'(count_clamped - kdop_pkg::CNT_WIDTH'(1));
		end else if (out_take) begin
			if (at_last) begin
				busy_q <= 1'b0;
			end else begin
				idx_q <= idx_q + kdop_pkg::IDX_WIDTH'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_valid) begin
			snap_low_q  <= load_low;
			snap_high_q <= load_high;
		end
	end

	always_comb begin
		bound.bound_low  = snap_low_q[0];
		bound.bound_high = snap_high_q[0];
		for (int d = 1; d < DIRECTIONS; d++) begin
			if (idx_q == kdop_pkg::IDX_WIDTH'(d)) begin
				bound.bound_low  = snap_low_q[d];
				bound.bound_high = snap_high_q[d];
			end
		end
	end

	assign bound.valid           = busy_q;
	assign bound.direction_index = idx_q;
	assign bound.last_bound      = at_last;

endmodule

`default_nettype wire
